/* rtl/rss_pkg.sv */
// shared types and constants for the random subset selector
`timescale 1ns / 1ps
`default_nettype none

package rss_pkg;

    localparam int MAX_ITEMS_DEF = 1024;
    localparam int RAND_BITS_DEF = 16;

    localparam int RAND_W       = 16;
    localparam int INDEX_W      = 10;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 16;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 11;

    localparam logic [CFG_ADDR_W-1:0] REG_NUM_ITEMS    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_SELECTED = 2'd1;

    localparam logic [CFG_DATA_W-1:0] NUM_ITEMS_RST    = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] NUM_SELECTED_RST = 11'd1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_SIZE,
        ST_DIV,
        ST_RD_SEL,
        ST_RD_LAST,
        ST_WR_SEL,
        ST_WR_LAST,
        ST_OUT
    } rss_state_t;

    typedef struct packed {
        logic in_ready;
        logic prep;
        logic size_load;
        logic div_step;
        logic rd_sel;
        logic rd_last;
        logic wr_sel;
        logic wr_last;
        logic out_load;
        logic clear_wr;
    } rss_cmd_t;

    typedef struct packed {
        logic pool_reset;
        logic clear_last;
        logic div_done;
        logic out_free;
    } rss_sts_t;

endpackage

`default_nettype wire

/* rtl/rss_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module rss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/rss_ctrl.sv */
// control state machine for the random subset selector
`timescale 1ns / 1ps
`default_nettype none

module rss_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire rss_pkg::rss_sts_t sts,
    output rss_pkg::rss_cmd_t      cmd
);
    import rss_pkg::*;

    rss_state_t state_reg;
    rss_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        if (sts.pool_reset) begin
            state_next = ST_CLEAR;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    if (sts.clear_last) state_next = ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_tvalid) state_next = ST_PREP;
                end
                ST_PREP:    state_next = ST_SIZE;
                ST_SIZE:    state_next = ST_DIV;
                ST_DIV: begin
                    if (sts.div_done) state_next = ST_RD_SEL;
                end
                ST_RD_SEL:  state_next = ST_RD_LAST;
                ST_RD_LAST: state_next = ST_WR_SEL;
                ST_WR_SEL:  state_next = ST_WR_LAST;
                ST_WR_LAST: state_next = ST_OUT;
                ST_OUT: begin
                    if (sts.out_free) state_next = ST_IDLE;
                end
                default:    state_next = ST_CLEAR;
            endcase
        end
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_CLEAR:   cmd.clear_wr  = 1'b1;
            ST_IDLE:    cmd.in_ready  = 1'b1;
            ST_PREP:    cmd.prep      = 1'b1;
            ST_SIZE:    cmd.size_load = 1'b1;
            ST_DIV:     cmd.div_step  = 1'b1;
            ST_RD_SEL:  cmd.rd_sel    = 1'b1;
            ST_RD_LAST: cmd.rd_last   = 1'b1;
            ST_WR_SEL:  cmd.wr_sel    = 1'b1;
            ST_WR_LAST: cmd.wr_last   = 1'b1;
            ST_OUT:     cmd.out_load  = sts.out_free;
            default:    cmd = '0;
        endcase
    end

    // pool memory sees at most one operation per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clear_wr, cmd.rd_sel, cmd.rd_last, cmd.wr_sel, cmd.wr_last}))
        else $error("overlapping pool memory commands");

    // a swap runs through to its second write unless a num_items write resets the pool
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_sel && !sts.pool_reset |=> cmd.wr_last)
        else $error("swap left half done");

endmodule

`default_nettype wire

/* rtl/rss_dp.sv */
// datapath: config registers, modulo unit, pool memory and output register
`timescale 1ns / 1ps
`default_nettype none

module rss_dp #(
    parameter int MAX_ITEMS = rss_pkg::MAX_ITEMS_DEF,
    parameter int RAND_BITS = rss_pkg::RAND_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire rss_pkg::rss_cmd_t               cmd,
    output rss_pkg::rss_sts_t                    sts,
    input  wire logic                            s_tvalid,
    input  wire logic [rss_pkg::RAND_W-1:0]      random_word,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [rss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic      [rss_pkg::INDEX_W-1:0]     chosen_index,
    output logic                                 round_done
);
    import rss_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int WIDE_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
    localparam int BCNT_W = $clog2(RAND_BITS);

    logic [CFG_DATA_W-1:0] num_items_reg;
    logic [CFG_DATA_W-1:0] num_selected_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;

    logic [RAND_BITS-1:0]  rand_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [CNT_W-1:0]      k_reg;
    logic [CNT_W-1:0]      dc_reg;
    logic [CNT_W-1:0]      dc_next;
    logic [CNT_W-1:0]      size_reg;
    logic [ADDR_W-1:0]     last_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      rem_next;
    logic [RAND_BITS-1:0]  shift_reg;
    logic [BCNT_W-1:0]     bit_cnt_reg;
    logic [ADDR_W-1:0]     picked_reg;

    logic                  out_valid_reg;
    logic [INDEX_W-1:0]    out_index_reg;
    logic                  out_last_reg;

    logic [RAND_BITS+RAND_W-1:0] rand_ext;
    logic [ADDR_W+INDEX_W-1:0]   picked_ext;
    logic [WIDE_W-1:0]           items_w;
    logic [WIDE_W-1:0]           sel_w;
    logic [WIDE_W-1:0]           n_w;
    logic [WIDE_W-1:0]           ks_w;
    logic [WIDE_W-1:0]           k_w;
    logic [CNT_W-1:0]            diff;
    logic [CNT_W-1:0]            last_full;
    logic [CNT_W:0]              rem_shift;
    logic [CNT_W:0]              rem_sub;
    logic [CNT_W-1:0]            dc_inc;
    logic                        draw_last;
    logic [ADDR_W-1:0]           sel_addr;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [ADDR_W-1:0]           ram_wdata;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [ADDR_W-1:0]           ram_rdata;

    // effective pool size and selection count
    always_comb begin
        items_w = WIDE_W'(num_items_reg);
        sel_w   = WIDE_W'(num_selected_reg);
        if (items_w == '0) begin
            n_w = WIDE_W'(1);
        end else if (items_w > WIDE_W'(MAX_ITEMS)) begin
            n_w = WIDE_W'(MAX_ITEMS);
        end else begin
            n_w = items_w;
        end
        ks_w = (sel_w == '0) ? WIDE_W'(1) : sel_w;
        k_w  = (ks_w > n_w) ? n_w : ks_w;
    end

    assign rand_ext   = {{RAND_BITS{1'b0}}, random_word};
    assign diff       = n_reg - dc_reg;
    assign last_full  = diff - CNT_W'(1);
    assign rem_shift  = {rem_reg, shift_reg[RAND_BITS-1]};
    assign rem_sub    = rem_shift - {1'b0, size_reg};
    assign rem_next   = (rem_shift >= {1'b0, size_reg}) ? rem_sub[CNT_W-1:0]
                                                        : rem_shift[CNT_W-1:0];
    assign dc_inc     = dc_reg + CNT_W'(1);
    assign draw_last  = (dc_inc >= k_reg);
    assign sel_addr   = rem_reg[ADDR_W-1:0];
    assign picked_ext = {{INDEX_W{1'b0}}, picked_reg};

    always_comb begin
        dc_next = dc_reg;
        if (cmd.prep) begin
            dc_next = (dc_reg >= k_w[CNT_W-1:0]) ? '0 : dc_reg;
        end else if (cmd.out_load) begin
            dc_next = draw_last ? '0 : dc_inc;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_items_reg    <= NUM_ITEMS_RST;
            num_selected_reg <= NUM_SELECTED_RST;
            dc_reg           <= '0;
            clr_addr_reg     <= '0;
            bit_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            dc_reg <= dc_next;
            if (cmd.clear_wr) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.size_load) begin
                bit_cnt_reg <= BCNT_W'(RAND_BITS - 1);
            end else if (cmd.div_step) begin
                bit_cnt_reg <= bit_cnt_reg - BCNT_W'(1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_NUM_ITEMS: begin
                        num_items_reg <= cfg_wdata;
                        dc_reg        <= '0;
                        clr_addr_reg  <= '0;
                    end
                    REG_NUM_SELECTED: num_selected_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.in_ready && s_tvalid) begin
            rand_reg <= rand_ext[RAND_BITS-1:0];
        end
        if (cmd.prep) begin
            n_reg <= n_w[CNT_W-1:0];
            k_reg <= k_w[CNT_W-1:0];
        end
        if (cmd.size_load) begin
            size_reg  <= diff;
            last_reg  <= last_full[ADDR_W-1:0];
            rem_reg   <= '0;
            shift_reg <= rand_reg;
        end else if (cmd.div_step) begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[RAND_BITS-2:0], 1'b0};
        end
        if (cmd.rd_last) begin
            picked_reg <= ram_rdata;
        end
        if (cmd.out_load) begin
            out_index_reg <= picked_ext[INDEX_W-1:0];
            out_last_reg  <= draw_last;
        end
    end

    // pool memory port selection
    always_comb begin
        ram_we    = cmd.clear_wr || cmd.wr_sel || cmd.wr_last;
        ram_waddr = clr_addr_reg;
        ram_wdata = clr_addr_reg;
        if (cmd.wr_sel) begin
            ram_waddr = sel_addr;
            ram_wdata = ram_rdata;
        end else if (cmd.wr_last) begin
            ram_waddr = last_reg;
            ram_wdata = picked_reg;
        end
        ram_raddr = cmd.rd_last ? last_reg : sel_addr;
    end

    rss_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_ITEMS)
    ) u_pool (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sts.pool_reset = cfg_wr_en && (cfg_addr == REG_NUM_ITEMS);
    assign sts.clear_last = (clr_addr_reg == ADDR_W'(MAX_ITEMS - 1));
    assign sts.div_done   = (bit_cnt_reg == '0);
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid     = out_valid_reg;
    assign chosen_index = out_index_reg;
    assign round_done   = out_last_reg;

    // partial remainder stays below the active pool size
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> rem_reg < size_reg)
        else $error("remainder out of range");

    // a held result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !cmd.out_load)
        else $error("output register overwritten");

    // pool writes stay inside the pool
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ram_waddr <= ADDR_W'(MAX_ITEMS - 1))
        else $error("pool write out of range");

endmodule

`default_nettype wire

/* rtl/random_subset_selector.sv */
// top level of the random subset selector (partial shuffle over an index pool)
//
//  port group  | dir | transfer contents
//  s_*         | in  | tdata[15:0] random_word
//  m_*         | out | tdata[9:0] chosen_index, tlast round_done
//  cfg_*       | in  | register write: 0 num_items, 1 num_selected
//
// each item passes the bit-serial modulo unit and the four pool memory accesses of the
// swap before its result is offered; the next input transfer is taken only once the
// result has been loaded into the output register.
// after reset and after every num_items write a pass over all MAX_ITEMS entries
// rewrites the pool to identity; s_tready stays low meanwhile.
// a result waits in the output register while the next item is taken in;
// a stall on m_tready holds the block only at the point where a new result is due.
`timescale 1ns / 1ps
`default_nettype none

module random_subset_selector #(
    parameter int MAX_ITEMS = rss_pkg::MAX_ITEMS_DEF,
    parameter int RAND_BITS = rss_pkg::RAND_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rss_pkg::IN_TDATA_W-1:0]  s_tdata,   // random_word
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [rss_pkg::OUT_TDATA_W-1:0] m_tdata,   // chosen_index
    output logic                                 m_tlast,   // round_done
    input  wire logic                            cfg_wr_en,
    input  wire logic [rss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [rss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rss_pkg::*;

    rss_cmd_t           cmd;
    rss_sts_t           sts;
    logic [INDEX_W-1:0] chosen_index;

    rss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    rss_dp #(
        .MAX_ITEMS (MAX_ITEMS),
        .RAND_BITS (RAND_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_tvalid     (s_tvalid),
        .random_word  (s_tdata[RAND_W-1:0]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .chosen_index (chosen_index),
        .round_done   (m_tlast)
    );

    assign s_tready = cmd.in_ready;
    assign m_tdata  = {{(OUT_TDATA_W - INDEX_W){1'b0}}, chosen_index};

endmodule

`default_nettype wire

/* verif/random_subset_selector_checker.sv */
// checker for the random subset selector: predicts every draw and compares the result stream
`timescale 1ns / 1ps

module random_subset_selector_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [rss_pkg::IN_TDATA_W-1:0]  s_tdata,   // random_word
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [rss_pkg::OUT_TDATA_W-1:0] m_tdata,   // chosen_index
    input  wire logic                            m_tlast,   // round_done
    input  wire logic                            cfg_wr_en,
    input  wire logic [rss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [rss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                                   fail_count,
    output int                                   pending
);
    import rss_pkg::*;

    localparam int REPORT_CAP = 50;

    typedef struct packed {
        logic [INDEX_W-1:0] chosen_index;
        logic               round_done;
    } draw_t;

    logic [INDEX_W-1:0]    index_store [MAX_ITEMS_DEF];
    logic [CFG_DATA_W-1:0] pool_size_reg;
    logic [CFG_DATA_W-1:0] round_len_reg;
    int unsigned           draws_in_round;
    draw_t                 expected_draws [$];
    int                    errors = 0;

    task automatic restore_identity();
        for (int i = 0; i < MAX_ITEMS_DEF; i++) begin
            index_store[i] = INDEX_W'(i);
        end
        draws_in_round = 0;
    endtask

    task automatic note_error(input string field, input int want, input int got);
        if (errors < REPORT_CAP) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
        end
        errors++;
    endtask

    // one partial shuffle step over the index store
    task automatic predict_draw(input logic [RAND_W-1:0] word, output draw_t res);
        int unsigned pool_size;
        int unsigned round_len;
        int unsigned active;
        int unsigned pick;
        int unsigned last;
        int unsigned word_val;
        logic [INDEX_W-1:0] taken;
        pool_size = pool_size_reg;
        if (pool_size == 0) pool_size = 1;
        if (pool_size > MAX_ITEMS_DEF) pool_size = MAX_ITEMS_DEF;
        round_len = round_len_reg;
        if (round_len == 0) round_len = 1;
        if (round_len > pool_size) round_len = pool_size;
        // selection count lowered mid-round starts a fresh round
        if (draws_in_round >= round_len) draws_in_round = 0;
        word_val = word;
        active   = pool_size - draws_in_round;
        last     = active - 1;
        pick     = word_val % active;
        taken             = index_store[pick];
        index_store[pick] = index_store[last];
        index_store[last] = taken;
        draws_in_round++;
        res.chosen_index = taken;
        res.round_done   = (draws_in_round >= round_len);
        if (res.round_done) draws_in_round = 0;
    endtask

    always @(posedge aclk) begin : watch
        draw_t got;
        draw_t want;
        if (!aresetn) begin
            restore_identity();
            pool_size_reg = NUM_ITEMS_RST;
            round_len_reg = NUM_SELECTED_RST;
            expected_draws.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_NUM_ITEMS) begin
                    pool_size_reg = cfg_wdata;
                    restore_identity();
                end else if (cfg_addr == REG_NUM_SELECTED) begin
                    round_len_reg = cfg_wdata;
                end
            end
            if (m_tvalid && m_tready) begin
                got.chosen_index = m_tdata[INDEX_W-1:0];
                got.round_done   = m_tlast;
                if (expected_draws.size() == 0) begin
                    if (errors < REPORT_CAP) begin
                        $error("unexpected result transfer: chosen_index %0d round_done %0b",
                               got.chosen_index, got.round_done);
                    end
                    errors++;
                end else begin
                    want = expected_draws.pop_front();
                    if (got.chosen_index !== want.chosen_index) begin
                        note_error("chosen_index", want.chosen_index, got.chosen_index);
                    end
                    if (got.round_done !== want.round_done) begin
                        note_error("round_done", want.round_done, got.round_done);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_draw(s_tdata[RAND_W-1:0], want);
                expected_draws.insert(expected_draws.size(), want);
            end
        end
        pending    <= expected_draws.size();
        fail_count <= errors;
    end

endmodule

/* verif/random_subset_selector_tb.sv */
// testbench top for the random subset selector: stimulus, flow control and verdict
`timescale 1ns / 1ps

module random_subset_selector_tb;
    import rss_pkg::*;

    localparam int ITEM_TARGET  = 1600;
    localparam int CALM_TAIL    = 200;
    localparam int HOLD_AT      = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;     // random_word
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;            // chosen_index
    logic                   m_tlast;            // round_done
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int fail_count;
    int pending;
    int results_seen = 0;
    int cycle_count  = 0;
    int items_sent   = 0;
    int sender_odds  = 0;
    logic calm = 1'b0;

    always #6 aclk = ~aclk;

    random_subset_selector i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    random_subset_selector_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side flow control, with one long hold-off to back the block up
    initial begin : result_sink
        int  r;
        bit  held;
        held = 1'b0;
        forever begin
            r = $urandom_range(0, 7);
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && r == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else if (r == 1) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_word(input logic [RAND_W-1:0] word);
        if (!calm && sender_odds != 0 && $urandom_range(1, sender_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (items_sent >= ITEM_TARGET - CALM_TAIL) calm <= 1'b1;
    endtask

    // stop offering and wait for every outstanding draw
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic configure(input bit write_items, input logic [CFG_DATA_W-1:0] items,
                             input logic [CFG_DATA_W-1:0] sel);
        if (write_items) cfg_write(REG_NUM_ITEMS, items);
        cfg_write(REG_NUM_SELECTED, sel);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        logic [CFG_DATA_W-1:0] items;
        logic [CFG_DATA_W-1:0] sel;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) items = 11'd1024;
        else if (pick == 1) items = 11'($urandom_range(0, 2047));
        else items = 11'($urandom_range(1, 32));
        pick = $urandom_range(0, 5);
        if (pick == 0) sel = 11'($urandom_range(0, 2047));
        else if (pick == 1) sel = items;
        else sel = 11'($urandom_range(1, int'(items) + 2));
        if ($urandom_range(0, 7) == 0) begin
            cfg_write(pick[0] ? REG_SPARE_A : REG_SPARE_B, 11'($urandom_range(0, 2047)));
        end
        configure($urandom_range(0, 3) != 0, items, sel);
        sender_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
        repeat (count) send_word(16'($urandom_range(0, 65535)));
        settle();
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: full pool, one draw per round
        sender_odds = 3;
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h03FF);
        send_word(16'h0400);
        send_word(16'h8000);
        send_word(16'h7FFF);
        settle();

        // zero pool size and zero selection count both act as one
        configure(1'b1, 11'd0, 11'd0);
        send_word(16'hFFFF);
        send_word(16'h0001);
        settle();

        // small pool, then the selection count lowered mid-round
        configure(1'b1, 11'd6, 11'd5);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'h1234);
        send_word(16'hFFFE);
        settle();
        cfg_write(REG_SPARE_A, 11'h7FF);
        cfg_write(REG_SPARE_B, 11'h000);
        configure(1'b0, 11'd0, 11'd2);
        send_word(16'h0005);
        send_word(16'hFFFF);
        send_word(16'h0003);
        settle();

        // oversized values clamp to the maximum pool
        configure(1'b1, 11'h7FF, 11'h7FF);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'hABCD);
        settle();
        configure(1'b1, 11'd1025, 11'd1);
        send_word(16'h5555);
        send_word(16'hAAAA);
        settle();

        // selection count above a single-entry pool
        configure(1'b1, 11'd1, 11'd1024);
        send_word(16'hFFFF);
        send_word(16'h8001);
        settle();

        configure(1'b1, 11'd2, 11'd2);
        send_word(16'h0001);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'h0002);
        settle();

        random_phase(200);

        // one complete round over the largest pool and into the next
        configure(1'b1, 11'd1024, 11'd1024);
        sender_odds = 6;
        repeat (1026) send_word(16'($urandom_range(0, 65535)));
        settle();

        while (items_sent < ITEM_TARGET) begin
            random_phase($urandom_range(20, 120));
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
